// ===== rtl/cht_pkg.sv =====
// Shared types and codes for the chained hash table engine; no dependencies.
// Used by cht_div, cht_dp, cht_ctrl and chained_hash_table_engine.
package cht_pkg;

	localparam logic [1:0] KIND_INSERT = 2'd0;
	localparam logic [1:0] KIND_LOOKUP = 2'd1;
	localparam logic [1:0] KIND_REMOVE = 2'd2;

	localparam logic [1:0] ST_DONE     = 2'd0;
	localparam logic [1:0] ST_NOTFOUND = 2'd1;
	localparam logic [1:0] ST_FULL     = 2'd2;

	localparam int         DIV_DIGITS  = 16;  // 64-bit hash word, 4 bits per step
	localparam logic [7:0] CFG_RESET   = 8'd127;

	typedef struct packed {
		logic clr_step;   // zero one bucket head
		logic load;       // accept an input beat
		logic div_step;   // one radix-16 step of the modulo
		logic head_rd;    // read bucket head, write the new node on insert
		logic head_take;  // take head as first node, or link new node as head
		logic node_rd;    // read node at cur
		logic node_chk;   // compare/advance/unlink at cur
		logic out_load;   // present the result
	} cmd_t;

	typedef struct packed {
		logic clr_done;
		logic skip;       // no walk needed (unused kind, full arena)
		logic div_last;
		logic head_zero;
		logic walk_end;
		logic out_free;
	} sts_t;

endpackage

// ===== rtl/cht_div.sv =====
// Sequential 64-bit by 8-bit remainder unit, four quotient bits per cycle in
// which step is high. Depends on cht_pkg.
module cht_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        step,
	input  logic [63:0] dividend,
	input  logic [7:0]  divisor,
	output logic [7:0]  rem,
	output logic        last
);

	logic [63:0] sh_q;
	logic [7:0]  rem_q;
	logic [3:0]  cnt_q;
	logic [7:0]  rem_nx;

	always_comb begin
		logic [8:0] t;
		rem_nx = rem_q;
		for (int i = 0; i < 4; i++) begin
			t = {rem_nx, sh_q[63 - i]};
			if (t >= {1'b0, divisor}) t = t - {1'b0, divisor};
			rem_nx = t[7:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= '0;
		end else if (step) begin
			cnt_q <= cnt_q + 4'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			sh_q  <= dividend;
			rem_q <= '0;
		end else if (step) begin
			sh_q  <= {sh_q[59:0], 4'd0};
			rem_q <= rem_nx;
		end
	end

	assign rem  = rem_q;
	assign last = (cnt_q == 4'(cht_pkg::DIV_DIGITS - 1));

endmodule

// ===== rtl/cht_dp.sv =====
// Datapath: item registers, bucket head memory, node arena, output register.
// Depends on cht_pkg and cht_div.
module cht_dp #(
	parameter int NODE_SLOTS   = 1024,
	parameter int BUCKET_SLOTS = 128
) (
	input  logic                clk,
	input  logic                arst_n,
	input  cht_pkg::cmd_t       cmd,
	output cht_pkg::sts_t       sts,
	input  logic [1:0]          kind,
	input  logic signed [31:0]  key_a,
	input  logic signed [31:0]  key_b,
	input  logic signed [31:0]  value_len,
	input  logic [31:0]         value_ref,
	input  logic                cfg_valid,
	input  logic [7:0]          cfg_data,
	input  logic                out_ready,
	output logic                out_valid,
	output logic [1:0]          status,
	output logic                found_hit,
	output logic signed [31:0]  result_len,
	output logic [31:0]         result_ref
);

	localparam int NW = $clog2(NODE_SLOTS);
	localparam int FW = $clog2(NODE_SLOTS + 1);
	localparam int BW = (BUCKET_SLOTS > 1) ? $clog2(BUCKET_SLOTS) : 1;
	localparam logic [7:0] BSAT = (BUCKET_SLOTS > 255) ? 8'd255 : 8'(BUCKET_SLOTS);

	logic [7:0]    cfg_q;
	logic [1:0]    kind_q;
	logic [63:0]   key_q;
	logic [63:0]   val_q;
	logic [1:0]    st_q;
	logic          hit_q;
	logic [63:0]   res_q;
	logic [FW-1:0] fill_q;
	logic [NW-1:0] cur_q;
	logic [NW-1:0] prev_q;
	logic [BW-1:0] clr_q;
	logic          ov_q;
	logic [1:0]    o_st_q;
	logic          o_hit_q;
	logic [63:0]   o_res_q;

	logic [NW-1:0] head_mem [BUCKET_SLOTS];
	logic [63:0]   key_mem  [NODE_SLOTS];
	logic [63:0]   val_mem  [NODE_SLOTS];
	logic [NW-1:0] link_mem [NODE_SLOTS];
	logic [NW-1:0] head_rd_q;
	logic [63:0]   key_rd_q;
	logic [63:0]   val_rd_q;
	logic [NW-1:0] link_rd_q;

	logic [7:0]    n_raw;
	logic [7:0]    n_eff;
	logic [7:0]    rem;
	logic          div_last;
	logic [BW-1:0] bkt;
	logic          full;
	logic [NW-1:0] fill_idx;
	logic          match;

	assign n_raw    = (cfg_q == 8'd0) ? 8'd1 : cfg_q;
	assign n_eff    = (n_raw > BSAT) ? BSAT : n_raw;
	assign bkt      = BW'(rem);
	assign full     = (fill_q >= FW'(NODE_SLOTS));
	assign fill_idx = fill_q[NW-1:0];
	assign match    = (key_rd_q == key_q);

	cht_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.load),
		.step     (cmd.div_step),
		.dividend ({key_b, key_a}),
		.divisor  (n_eff),
		.rem      (rem),
		.last     (div_last)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q  <= cht_pkg::CFG_RESET;
			fill_q <= FW'(1);
			clr_q  <= '0;
			ov_q   <= 1'b0;
		end else begin
			if (cfg_valid) cfg_q <= cfg_data;
			if (cmd.clr_step) clr_q <= clr_q + BW'(1);
			if ((cmd.head_take && head_rd_q == '0 && kind_q == cht_pkg::KIND_INSERT) ||
			    (cmd.node_chk && kind_q == cht_pkg::KIND_INSERT && link_rd_q == '0))
				fill_q <= fill_q + FW'(1);
			if (cmd.out_load) ov_q <= 1'b1;
			else if (out_ready) ov_q <= 1'b0;
		end
	end

	// item registers, walk pointers and output register
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q <= kind;
			key_q  <= {key_b, key_a};
			val_q  <= {value_ref, value_len};
			hit_q  <= 1'b0;
			res_q  <= '0;
			case (kind)
				cht_pkg::KIND_INSERT: st_q <= full ? cht_pkg::ST_FULL : cht_pkg::ST_DONE;
				cht_pkg::KIND_LOOKUP, cht_pkg::KIND_REMOVE: st_q <= cht_pkg::ST_NOTFOUND;
				default: st_q <= cht_pkg::ST_DONE;
			endcase
		end
		if (cmd.head_take) begin
			cur_q  <= head_rd_q;
			prev_q <= '0;
		end
		if (cmd.node_chk) begin
			cur_q <= link_rd_q;
			if (kind_q == cht_pkg::KIND_REMOVE && !match) prev_q <= cur_q;
			if (match && kind_q != cht_pkg::KIND_INSERT) begin
				st_q  <= cht_pkg::ST_DONE;
				hit_q <= 1'b1;
				if (kind_q == cht_pkg::KIND_LOOKUP) res_q <= val_rd_q;
			end
		end
		if (cmd.out_load) begin
			o_st_q  <= st_q;
			o_hit_q <= hit_q;
			o_res_q <= res_q;
		end
	end

	// bucket head memory: clear sweep, head read, head update
	always_ff @(posedge clk) begin
		if (cmd.clr_step)
			head_mem[clr_q] <= '0;
		else if (cmd.head_take && head_rd_q == '0 && kind_q == cht_pkg::KIND_INSERT)
			head_mem[bkt] <= fill_idx;
		else if (cmd.node_chk && kind_q == cht_pkg::KIND_REMOVE && match && prev_q == '0)
			head_mem[bkt] <= link_rd_q;
		if (cmd.head_rd) head_rd_q <= head_mem[bkt];
	end

	// node arena; the new node is written before the walk, it is in no chain yet
	always_ff @(posedge clk) begin
		if (cmd.head_rd && kind_q == cht_pkg::KIND_INSERT) begin
			key_mem[fill_idx] <= key_q;
			val_mem[fill_idx] <= val_q;
		end
		if (cmd.head_rd && kind_q == cht_pkg::KIND_INSERT)
			link_mem[fill_idx] <= '0;
		else if (cmd.node_chk && kind_q == cht_pkg::KIND_INSERT && link_rd_q == '0)
			link_mem[cur_q] <= fill_idx;
		else if (cmd.node_chk && kind_q == cht_pkg::KIND_REMOVE && match && prev_q != '0)
			link_mem[prev_q] <= link_rd_q;
		if (cmd.node_rd) begin
			key_rd_q  <= key_mem[cur_q];
			val_rd_q  <= val_mem[cur_q];
			link_rd_q <= link_mem[cur_q];
		end
	end

	always_comb begin
		sts.clr_done  = (clr_q == BW'(BUCKET_SLOTS - 1));
		sts.skip      = (kind_q == cht_pkg::KIND_INSERT) ? full :
		                !(kind_q == cht_pkg::KIND_LOOKUP || kind_q == cht_pkg::KIND_REMOVE);
		sts.div_last  = div_last;
		sts.head_zero = (head_rd_q == '0);
		sts.walk_end  = (link_rd_q == '0) || (kind_q == cht_pkg::KIND_LOOKUP && match);
		sts.out_free  = !ov_q || out_ready;
	end

	assign out_valid  = ov_q;
	assign status     = o_st_q;
	assign found_hit  = o_hit_q;
	assign result_len = o_res_q[31:0];
	assign result_ref = o_res_q[63:32];

endmodule

// ===== rtl/cht_ctrl.sv =====
// Controller FSM: sequences clear, modulo, head read, chain walk and result.
// Depends on cht_pkg.
module cht_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  cht_pkg::sts_t sts,
	output cht_pkg::cmd_t cmd
);

	typedef enum logic [7:0] {
		S_CLEAR = 8'b0000_0001,
		S_IDLE  = 8'b0000_0010,
		S_DIV   = 8'b0000_0100,
		S_HRD   = 8'b0000_1000,
		S_HCHK  = 8'b0001_0000,
		S_NRD   = 8'b0010_0000,
		S_NCHK  = 8'b0100_0000,
		S_RESP  = 8'b1000_0000
	} state_t;

	state_t state_q, state_nx;

	always_comb begin
		state_nx = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			S_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_done) state_nx = S_IDLE;
			end
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_nx = S_DIV;
				end
			end
			S_DIV: begin
				if (sts.skip) begin
					state_nx = S_RESP;
				end else begin
					cmd.div_step = 1'b1;
					if (sts.div_last) state_nx = S_HRD;
				end
			end
			S_HRD: begin
				cmd.head_rd = 1'b1;
				state_nx    = S_HCHK;
			end
			S_HCHK: begin
				cmd.head_take = 1'b1;
				state_nx      = sts.head_zero ? S_RESP : S_NRD;
			end
			S_NRD: begin
				cmd.node_rd = 1'b1;
				state_nx    = S_NCHK;
			end
			S_NCHK: begin
				cmd.node_chk = 1'b1;
				state_nx     = sts.walk_end ? S_RESP : S_NRD;
			end
			S_RESP: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_nx     = S_IDLE;
				end
			end
			default: state_nx = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_CLEAR;
		else state_q <= state_nx;
	end

endmodule

// ===== rtl/chained_hash_table_engine.sv =====
// Hash map of (key_a, key_b) to (len, ref) with per-bucket chains in a node arena.
// Input beats carry an insert, lookup or remove; each gives exactly one output beat.
// cfg_data sets the bucket count (0 acts as 1, saturates at BUCKET_SLOTS); write it
// only while no item is in flight. Its reset value is 127.
// After reset the bucket heads are swept to empty with in_ready low; the node arena
// needs no clearing.
// Steps per item: accept in the idle state, the 64-bit modulo (4 bits per cycle in
// the remainder unit), the head read and head check, and per chain node visited a
// registered read of the node memories then a compare/link update; then the result.
// Insert walks the whole chain; lookup stops at the first match; remove walks it all.
// Unused kind and insert into a full arena skip the modulo and walk.
// One item at a time: in_ready is high only while the block is idle.
// The result sits in an output register until out_ready takes the beat; a stalled
// receiver holds the block in its result state, and the next item is then accepted
// in the cycle after the beat moves into the register.
// Depends on cht_pkg, cht_ctrl, cht_dp, cht_div.
module chained_hash_table_engine #(
	parameter int NODE_SLOTS   = 1024,
	parameter int BUCKET_SLOTS = 128
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         kind,
	input  logic signed [31:0] key_a,
	input  logic signed [31:0] key_b,
	input  logic signed [31:0] value_len,
	input  logic [31:0]        value_ref,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         status,
	output logic               found_hit,
	output logic signed [31:0] result_len,
	output logic [31:0]        result_ref,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [7:0]         cfg_data
);

	cht_pkg::cmd_t cmd;
	cht_pkg::sts_t sts;

	assign cfg_ready = 1'b1;

	cht_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	cht_dp #(
		.NODE_SLOTS   (NODE_SLOTS),
		.BUCKET_SLOTS (BUCKET_SLOTS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.kind       (kind),
		.key_a      (key_a),
		.key_b      (key_b),
		.value_len  (value_len),
		.value_ref  (value_ref),
		.cfg_valid  (cfg_valid),
		.cfg_data   (cfg_data),
		.out_ready  (out_ready),
		.out_valid  (out_valid),
		.status     (status),
		.found_hit  (found_hit),
		.result_len (result_len),
		.result_ref (result_ref)
	);

endmodule

// ===== sim/chained_hash_table_engine_test.sv =====
// Self-checking bench for chained_hash_table_engine: directed and random insert/lookup/remove
// beats predicted by a behavioral hash map, with bucket-count changes between phases.
// Depends on cht_pkg and the engine RTL.
module chained_hash_table_engine_test;

	localparam int NODES   = 1024;
	localparam int BUCKETS = 128;

	// kind code with no operation behind it
	localparam logic [1:0] KIND_SPARE = 2'd3;

	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] key_a;
		logic [31:0] key_b;
		logic [31:0] value_len;
		logic [31:0] value_ref;
	} op_t;

	typedef struct packed {
		logic [1:0]  status;
		logic        found_hit;
		logic [31:0] result_len;
		logic [31:0] result_ref;
	} reply_t;

	logic clk, arst_n;
	logic in_valid, in_ready;
	logic [1:0] kind;
	logic signed [31:0] key_a, key_b, value_len;
	logic [31:0] value_ref;
	logic out_valid, out_ready;
	logic [1:0] status;
	logic found_hit;
	logic signed [31:0] result_len;
	logic [31:0] result_ref;
	logic cfg_valid, cfg_ready;
	logic [7:0] cfg_data;

	chained_hash_table_engine dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.kind(kind), .key_a(key_a), .key_b(key_b),
		.value_len(value_len), .value_ref(value_ref),
		.out_valid(out_valid), .out_ready(out_ready),
		.status(status), .found_hit(found_hit),
		.result_len(result_len), .result_ref(result_ref),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	// map model state
	logic [7:0]  map_buckets;
	logic [9:0]  map_heads [BUCKETS];
	logic [63:0] map_keys  [NODES];
	logic [63:0] map_vals  [NODES];
	logic [9:0]  map_links [NODES];
	int          map_fill;

	op_t    op_queue [$];
	reply_t reply_queue [$];
	bit     failed;
	bit     hold_off_req;
	int     burst_left, gap_left, stall_left;

	// Apply one operation to the map and return the reply it produces.
	function automatic reply_t map_apply(op_t o);
		reply_t r;
		logic [63:0] k;
		int n, b, cur, prev, nxt, steps;
		r = '0;
		k = {o.key_b, o.key_a};
		n = (map_buckets == 0) ? 1 : ((map_buckets > BUCKETS) ? BUCKETS : int'(map_buckets));
		b = int'(k % 64'(n));
		case (o.kind)
			cht_pkg::KIND_INSERT: begin
				if (map_fill >= NODES) begin
					r.status = cht_pkg::ST_FULL;
				end else begin
					map_keys[map_fill] = k;
					map_vals[map_fill] = {o.value_ref, o.value_len};
					map_links[map_fill] = '0;
					cur = map_heads[b];
					if (cur == 0) begin
						map_heads[b] = 10'(map_fill);
					end else begin
						while (map_links[cur] != 0)
							cur = map_links[cur];
						map_links[cur] = 10'(map_fill);
					end
					map_fill++;
				end
			end
			cht_pkg::KIND_LOOKUP: begin
				r.status = cht_pkg::ST_NOTFOUND;
				cur = map_heads[b];
				steps = 0;
				while (cur != 0 && steps < NODES) begin
					if (map_keys[cur] == k) begin
						r.status = cht_pkg::ST_DONE;
						r.found_hit = 1'b1;
						r.result_len = map_vals[cur][31:0];
						r.result_ref = map_vals[cur][63:32];
						break;
					end
					cur = map_links[cur];
					steps++;
				end
			end
			cht_pkg::KIND_REMOVE: begin
				r.status = cht_pkg::ST_NOTFOUND;
				prev = 0;
				cur = map_heads[b];
				steps = 0;
				while (cur != 0 && steps < NODES) begin
					nxt = map_links[cur];
					if (map_keys[cur] == k) begin
						if (prev == 0) map_heads[b] = 10'(nxt);
						else map_links[prev] = 10'(nxt);
						r.status = cht_pkg::ST_DONE;
						r.found_hit = 1'b1;
					end else begin
						prev = cur;
					end
					cur = nxt;
					steps++;
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	// sender: bursts and gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 0;
			kind <= 0; key_a <= 0; key_b <= 0; value_len <= 0; value_ref <= 0;
			burst_left = 0;
			gap_left = 0;
		end else begin
			if (in_valid && in_ready)
				reply_queue.push_back(map_apply({kind, key_a, key_b, value_len, value_ref}));
			if (!in_valid || in_ready) begin
				if (burst_left == 0 && gap_left == 0) begin
					burst_left = $urandom_range(1, 20);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
				end
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 0;
				end else if (op_queue.size() > 0) begin
					op_t o;
					o = op_queue.pop_front();
					burst_left--;
					in_valid <= 1;
					kind <= o.kind; key_a <= o.key_a; key_b <= o.key_b;
					value_len <= o.value_len; value_ref <= o.value_ref;
				end else begin
					in_valid <= 0;
				end
			end
		end
	end

	// receiver: own stall pattern, plus a long hold-off on request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 0;
			stall_left = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (reply_queue.size() == 0) begin
					$error("result beat with no expectation");
					failed = 1;
				end else begin
					reply_t e;
					e = reply_queue.pop_front();
					if (status !== e.status) begin
						$error("status exp %0d got %0d", e.status, status);
						failed = 1;
					end
					if (found_hit !== e.found_hit) begin
						$error("found_hit exp %0d got %0d", e.found_hit, found_hit);
						failed = 1;
					end
					if (result_len !== e.result_len) begin
						$error("result_len exp %h got %h", e.result_len, result_len);
						failed = 1;
					end
					if (result_ref !== e.result_ref) begin
						$error("result_ref exp %h got %h", e.result_ref, result_ref);
						failed = 1;
					end
				end
			end
			if (hold_off_req) begin
				hold_off_req = 0;
				stall_left = 400;
			end
			if (stall_left > 0) begin
				stall_left--;
				out_ready <= 0;
			end else if ($urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(1, 30);
				out_ready <= 0;
			end else begin
				out_ready <= ($urandom_range(0, 3) != 0);
			end
		end
	end

	function automatic op_t rand_op(int key_span, int kinds);
		op_t o;
		o.kind = 2'($urandom_range(0, kinds));
		if (key_span == 0) begin
			o.key_a = $urandom;
			o.key_b = $urandom;
		end else begin
			o.key_a = $urandom_range(0, key_span);
			o.key_b = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 2);
			if ($urandom_range(0, 7) == 0) o.key_a = -o.key_a;
		end
		o.value_len = $urandom;
		o.value_ref = $urandom;
		return o;
	endfunction

	task automatic write_buckets(logic [7:0] v);
		@(posedge clk);
		cfg_valid <= 1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		map_buckets = v;
		cfg_valid <= 0;
	endtask

	task automatic drain();
		while (op_queue.size() > 0 || reply_queue.size() > 0 || in_valid)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	initial begin
		op_t o;
		failed = 0;
		hold_off_req = 0;
		map_buckets = cht_pkg::CFG_RESET;
		map_fill = 1;
		foreach (map_heads[i]) map_heads[i] = '0;
		cfg_valid = 0;
		cfg_data = 0;
		arst_n = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1;

		// directed: extremes, every kind, duplicates, misses, unused kind
		o = op_t'{cht_pkg::KIND_INSERT, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
		          32'hffff_ffff};
		op_queue.push_back(o);
		o.value_len = 32'h7fff_ffff; o.value_ref = 0;
		op_queue.push_back(o);                  // duplicate key
		o.kind = cht_pkg::KIND_LOOKUP; op_queue.push_back(o);
		o.kind = cht_pkg::KIND_REMOVE; op_queue.push_back(o);
		op_queue.push_back(o);                  // remove miss
		o.kind = cht_pkg::KIND_LOOKUP; op_queue.push_back(o);
		op_queue.push_back(op_t'{cht_pkg::KIND_INSERT, 32'hffff_ffff, 32'hffff_ffff,
		                         32'd5, 32'd6});
		op_queue.push_back(op_t'{cht_pkg::KIND_INSERT, 32'd0, 32'd0, 32'd1, 32'd2});
		op_queue.push_back(op_t'{cht_pkg::KIND_LOOKUP, 32'hffff_ffff, 32'hffff_ffff,
		                         32'd0, 32'd0});
		op_queue.push_back(op_t'{cht_pkg::KIND_LOOKUP, 32'd0, 32'd0, 32'd0, 32'd0});
		op_queue.push_back(op_t'{KIND_SPARE, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
		                         32'hffff_ffff});
		op_queue.push_back(op_t'{cht_pkg::KIND_REMOVE, 32'd0, 32'd0, 32'd0, 32'd0});
		// same bucket under modulus 127, middle-of-chain remove
		op_queue.push_back(op_t'{cht_pkg::KIND_INSERT, 32'd3, 32'd0, 32'd10, 32'd11});
		op_queue.push_back(op_t'{cht_pkg::KIND_INSERT, 32'd130, 32'd0, 32'd12, 32'd13});
		op_queue.push_back(op_t'{cht_pkg::KIND_INSERT, 32'd257, 32'd0, 32'd14, 32'd15});
		op_queue.push_back(op_t'{cht_pkg::KIND_REMOVE, 32'd130, 32'd0, 32'd0, 32'd0});
		op_queue.push_back(op_t'{cht_pkg::KIND_LOOKUP, 32'd257, 32'd0, 32'd0, 32'd0});
		op_queue.push_back(op_t'{cht_pkg::KIND_INSERT, 32'd384, 32'd0, 32'd16, 32'd17});
		op_queue.push_back(op_t'{cht_pkg::KIND_LOOKUP, 32'd384, 32'd0, 32'd0, 32'd0});
		drain();

		// bucket count sweep, including out-of-range and changes with live chains
		write_buckets(8'd0);
		repeat (60) op_queue.push_back(rand_op(20, 3));
		drain();
		write_buckets(8'd255);
		repeat (200) op_queue.push_back(rand_op(300, 2));
		hold_off_req = 1;          // receiver blocks while sender keeps offering
		drain();
		write_buckets(8'd1);
		repeat (150) op_queue.push_back(rand_op(40, 2));
		drain();
		write_buckets(8'd128);
		repeat (300) op_queue.push_back(rand_op(200, 2));
		drain();
		write_buckets(8'd13);
		repeat (300) op_queue.push_back(rand_op(($urandom_range(0, 1)) ? 60 : 0, 3));
		drain();
		// insert-heavy phase that grows the arena, then mixed probes
		write_buckets(8'd127);
		repeat (400) begin
			o = rand_op(500, 2);
			if ($urandom_range(0, 1)) o.kind = cht_pkg::KIND_INSERT;
			op_queue.push_back(o);
		end
		repeat (300) op_queue.push_back(rand_op(500, 3));
		drain();

		if (!failed)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#60000000;
		$display("Test completed with failures");
		$finish;
	end
endmodule

// ===== chained_hash_table_engine.f =====
rtl/cht_pkg.sv
rtl/cht_div.sv
rtl/cht_dp.sv
rtl/cht_ctrl.sv
rtl/chained_hash_table_engine.sv
sim/chained_hash_table_engine_test.sv
